@@ src/cts_pkg.sv @@
// Shared types, opcodes and tag codes for the compact token serializer.
// No dependencies.
package cts_pkg;

  // Input opcodes
  typedef enum logic [3:0] {
    OP_INT       = 4'd0,
    OP_DOUBLE    = 4'd1,
    OP_STR_HEAD  = 4'd2,
    OP_STR_BYTE  = 4'd3,
    OP_ARR_BEGIN = 4'd4,
    OP_MAP_BEGIN = 4'd5,
    OP_ARR_END   = 4'd6,
    OP_MAP_END   = 4'd7,
    OP_TRUE      = 4'd8,
    OP_FALSE     = 4'd9,
    OP_NULL      = 4'd10
  } opcode_t;

  // Tag codes
  localparam logic [7:0] TAG_DBL_N1    = 8'd125;
  localparam logic [7:0] TAG_DBL_0     = 8'd126;
  localparam logic [7:0] TAG_DBL_1     = 8'd127;
  localparam logic [7:0] TAG_STR_FIX   = 8'd128;
  localparam logic [7:0] TAG_STR8      = 8'd228;
  localparam logic [7:0] TAG_STR16     = 8'd229;
  localparam logic [7:0] TAG_STR32     = 8'd230;
  localparam logic [7:0] TAG_STR64     = 8'd231;
  localparam logic [7:0] TAG_I8        = 8'd232;
  localparam logic [7:0] TAG_I16       = 8'd233;
  localparam logic [7:0] TAG_I32       = 8'd234;
  localparam logic [7:0] TAG_I64       = 8'd235;
  localparam logic [7:0] TAG_DBL       = 8'd236;
  localparam logic [7:0] TAG_ARR0      = 8'd237;
  localparam logic [7:0] TAG_MAP0      = 8'd243;
  localparam logic [7:0] TAG_TRUE      = 8'd249;
  localparam logic [7:0] TAG_FALSE     = 8'd250;
  localparam logic [7:0] TAG_NULL      = 8'd251;
  localparam logic [7:0] TAG_ARR_OPEN  = 8'd252;
  localparam logic [7:0] TAG_MAP_OPEN  = 8'd253;
  localparam logic [7:0] TAG_ARR_CLOSE = 8'd254;
  localparam logic [7:0] TAG_MAP_CLOSE = 8'd255;

  // Special double patterns
  localparam logic [63:0] DBL_NEG_ONE  = 64'hBFF0_0000_0000_0000;
  localparam logic [63:0] DBL_POS_ONE  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DBL_NEG_ZERO = 64'h8000_0000_0000_0000;

  localparam logic [62:0] STR_FIX_LIMIT = 63'd100;
  localparam logic [2:0]  CONT_FIX_LIMIT = 3'd6;
  localparam logic signed [7:0] INT_NEG_LIMIT = -8'sd60;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // Encoded token: tag in the low byte, payload above it, little-endian.
  typedef struct packed {
    logic [71:0] bytes;
    logic [3:0]  nbytes;   // 1..9
  } tok_t;

endpackage

@@ src/cts_front.sv @@
// Front end: classifies one token and builds its tag and payload bytes.
// Depends on cts_pkg.
module cts_front (
  input  logic                accept,
  input  logic [3:0]          opcode,
  input  logic signed [63:0]  int_value,
  input  logic [63:0]         double_bits,
  input  logic [62:0]         count,
  input  logic [7:0]          data_byte,
  output logic                push,
  output cts_pkg::tok_t       tok
);
  import cts_pkg::*;

  logic        emit;
  logic [7:0]  tag;
  logic [63:0] payload;
  logic [3:0]  plen;
  logic [63:0] ival;
  logic        neg, fit8, fit16, fit32;
  logic        cnt_small;

  assign ival  = int_value;
  assign neg   = ival[63];
  // fits in n-bit signed when the bits from n-1 upward all match the sign
  assign fit8  = (ival[63:7]  == {57{neg}});
  assign fit16 = (ival[63:15] == {49{neg}});
  assign fit32 = (ival[63:31] == {33{neg}});
  assign cnt_small = (count[62:3] == '0) && (count[2:0] < CONT_FIX_LIMIT);

  always_comb begin
    emit    = 1'b1;
    tag     = '0;
    payload = '0;
    plen    = 4'd0;
    unique case (opcode_t'(opcode))
      OP_INT: begin
        payload = ival;
        if (fit8) begin
          if (!neg && !ival[6]) begin
            tag = ival[7:0];
          end else if (neg && ($signed(ival[7:0]) >= INT_NEG_LIMIT)) begin
            tag = 8'd63 - ival[7:0];
          end else begin
            tag  = TAG_I8;
            plen = 4'd1;
          end
        end else if (fit16) begin
          tag  = TAG_I16;
          plen = 4'd2;
        end else if (fit32) begin
          tag  = TAG_I32;
          plen = 4'd4;
        end else begin
          tag  = TAG_I64;
          plen = 4'd8;
        end
      end
      OP_DOUBLE: begin
        payload = double_bits;
        if (double_bits == DBL_NEG_ONE) begin
          tag = TAG_DBL_N1;
        end else if (double_bits == '0 || double_bits == DBL_NEG_ZERO) begin
          tag = TAG_DBL_0;
        end else if (double_bits == DBL_POS_ONE) begin
          tag = TAG_DBL_1;
        end else begin
          tag  = TAG_DBL;
          plen = 4'd8;
        end
      end
      OP_STR_HEAD: begin
        payload = {1'b0, count};
        if (count < STR_FIX_LIMIT) begin
          tag = TAG_STR_FIX + {1'b0, count[6:0]};
        end else if (count[62:8] == '0) begin
          tag  = TAG_STR8;
          plen = 4'd1;
        end else if (count[62:16] == '0) begin
          tag  = TAG_STR16;
          plen = 4'd2;
        end else if (count[62:32] == '0) begin
          tag  = TAG_STR32;
          plen = 4'd4;
        end else begin
          tag  = TAG_STR64;
          plen = 4'd8;
        end
      end
      OP_STR_BYTE:  tag = data_byte;
      OP_ARR_BEGIN: tag = cnt_small ? TAG_ARR0 + {5'd0, count[2:0]} : TAG_ARR_OPEN;
      OP_MAP_BEGIN: tag = cnt_small ? TAG_MAP0 + {5'd0, count[2:0]} : TAG_MAP_OPEN;
      OP_ARR_END: begin
        tag  = TAG_ARR_CLOSE;
        emit = !cnt_small;
      end
      OP_MAP_END: begin
        tag  = TAG_MAP_CLOSE;
        emit = !cnt_small;
      end
      OP_TRUE:  tag = TAG_TRUE;
      OP_FALSE: tag = TAG_FALSE;
      OP_NULL:  tag = TAG_NULL;
      default:  emit = 1'b0;
    endcase
  end

  assign push       = accept && emit;
  assign tok.bytes  = {payload, tag};
  assign tok.nbytes = plen + 4'd1;

endmodule

@@ src/cts_queue.sv @@
// Short token queue between front and back, flip-flop storage.
// Depends on cts_pkg.
module cts_queue #(
  parameter int DEPTH = cts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cts_pkg::tok_t push_tok,
  input  logic          pop,
  output logic          nonempty,
  output logic          full,
  output cts_pkg::tok_t head
);
  import cts_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  tok_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push, do_pop;

  assign nonempty = (fill != '0);
  assign full     = (fill == FULL_CNT);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue: push while full");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= FULL_CNT)
    else $error("queue: fill count out of range");
`endif

endmodule

@@ src/cts_back.sv @@
// Back end: shifts out a queued token one byte per cycle, registered output.
// Depends on cts_pkg.
module cts_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_nonempty,
  input  cts_pkg::tok_t q_head,
  output logic          pop,
  output logic          strobe,
  output logic [7:0]    out_byte,
  output logic          last
);
  import cts_pkg::*;

  logic [71:0] cur_bytes;
  logic [3:0]  cur_n;      // bytes still to send, 0 when idle

  // take the next token when idle or when sending the final byte
  assign pop = q_nonempty && (cur_n <= 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_n  <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= (cur_n != '0);
      if (pop) begin
        cur_n <= q_head.nbytes;
      end else if (cur_n != '0) begin
        cur_n <= cur_n - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_byte <= cur_bytes[7:0];
    last     <= (cur_n == 4'd1);
    if (pop) begin
      cur_bytes <= q_head.bytes;
    end else begin
      cur_bytes <= {8'd0, cur_bytes[71:8]};
    end
  end

`ifndef ASSERT_OFF
  a_burst_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("back: gap inside a token");
  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !strobe)
    else $error("back: strobe straight after reset");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) cur_n <= 4'd9)
    else $error("back: byte count out of range");
`endif

endmodule

@@ src/compact_token_serializer.sv @@
// Top level of the compact token serializer: front classifier, token queue
// and byte-wide back end. Depends on cts_pkg, cts_front, cts_queue, cts_back.
//
// Usage: present a token with start high; it is taken on any rising edge at
// which busy is low. Each token gives 0 to 9 output words (one byte each),
// shown for one cycle with strobe high and last high on the final byte; the
// receiver cannot stall. Tokens that give no bytes (short container ends,
// unknown opcodes) are dropped at the front. The first byte of a token
// passes through a queue entry, the back end's shift register and the
// output register before it appears. The back end sends exactly one byte
// per cycle, so single-byte tokens (string payload, small ints, tags)
// sustain one token per clock, while a multi-byte token holds the output
// until its last byte. The queue of QUEUE_DEPTH entries absorbs that
// difference; busy rises when it is full and falls as the back end drains it.
module compact_token_serializer #(
  parameter int QUEUE_DEPTH = cts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         opcode,
  input  logic signed [63:0] int_value,
  input  logic [63:0]        double_bits,
  input  logic [62:0]        count,
  input  logic [7:0]         data_byte,
  output logic               strobe,
  output logic [7:0]         out_byte,
  output logic               last
);
  import cts_pkg::*;

  logic accept;
  logic push, pop;
  logic q_nonempty, q_full;
  tok_t push_tok, q_head;

  // input word taken when start meets a free queue slot
  assign busy   = q_full;
  assign accept = start && !busy;

  cts_front u_front (
    .accept      (accept),
    .opcode      (opcode),
    .int_value   (int_value),
    .double_bits (double_bits),
    .count       (count),
    .data_byte   (data_byte),
    .push        (push),
    .tok         (push_tok)
  );

  // decouples classification from the byte-serial back end
  cts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .nonempty (q_nonempty),
    .full     (q_full),
    .head     (q_head)
  );

  cts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (pop),
    .strobe     (strobe),
    .out_byte   (out_byte),
    .last       (last)
  );

endmodule
